[src/rpsb_pkg.sv]
// shared constants and types of the radial power spectrum binner
`default_nettype none
package rpsb_pkg;

  localparam int unsigned MAX_GRID_DEF = 256;
  localparam int unsigned MAX_BINS_DEF = 64;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned FIRST_W = 8;
  localparam int unsigned NBIN_W = 7;
  localparam int unsigned NORM_W = 32;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned SUM_W = 64;
  localparam int unsigned CNT_W = 25;
  localparam int unsigned BIN_IDX_W = 6;
  localparam int unsigned D2_USE_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE_X = 3'd0,
    CFG_GRID_SIZE_Y = 3'd1,
    CFG_GRID_SIZE_Z = 3'd2,
    CFG_SLAB_FIRST_PLANE = 3'd3,
    CFG_SLAB_PLANE_COUNT = 3'd4,
    CFG_BIN_COUNT = 3'd5,
    CFG_POWER_NORM = 3'd6
  } cfg_reg_e;

  localparam logic [SIZE_W-1:0] RST_GRID_SIZE = 9'd256;
  localparam logic [FIRST_W-1:0] RST_FIRST_PLANE = 8'd0;
  localparam logic [NBIN_W-1:0] RST_BIN_COUNT = 7'd64;
  localparam logic [NORM_W-1:0] RST_POWER_NORM = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

[src/rpsb_ram.sv]
// generic single-write single-read ram with registered read
`default_nettype none
module rpsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[src/radial_power_spectrum_binner_3d.sv]
// top level of the radial power spectrum binner: bin pipeline, bin store and drain
// path: an accepted item passes front stages s0 to s3, the bin search stages and the m stage before the bin store
// throughput: one item per cycle within a slab, set by the read-modify-write on the bin ram
// end of slab: flush, then per bin read, load, bit-serial divide and put; then run again
// reset: config and control registers take their reset values, all bin valid bits clear, so every bin reads zero
// no clearing pass: a drain clears all valid bits at once when its last bin is handed out
`default_nettype none
module radial_power_spectrum_binner_3d #(
  parameter int unsigned MAX_GRID = rpsb_pkg::MAX_GRID_DEF,
  parameter int unsigned MAX_BINS = rpsb_pkg::MAX_BINS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [rpsb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [rpsb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [rpsb_pkg::COEF_W-1:0]   coef_real_i,
  input  wire logic signed [rpsb_pkg::COEF_W-1:0]   coef_imag_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [rpsb_pkg::BIN_IDX_W-1:0]            bin_index_o,
  output logic [rpsb_pkg::SUM_W-1:0]                mean_power_o,
  output logic [rpsb_pkg::CNT_W-1:0]                point_count_o,
  output logic                                      last_bin_o
);

  localparam int unsigned SW = rpsb_pkg::SIZE_W;
  localparam int unsigned NW = rpsb_pkg::NBIN_W;
  localparam int unsigned PW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int unsigned CW = (PW + 1 > SW) ? PW + 1 : SW;
  localparam int unsigned GW = ((PW > rpsb_pkg::FIRST_W) ? PW : rpsb_pkg::FIRST_W) + 1;
  localparam int unsigned KW = GW + 1;
  localparam int unsigned DW = 2 * GW + 2;
  localparam int unsigned BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned SD = 2 * BW;
  localparam int unsigned LW = BW + 10;
  localparam int unsigned RW = 2 * LW;
  localparam int unsigned SUMW = rpsb_pkg::SUM_W;
  localparam int unsigned CNTW = rpsb_pkg::CNT_W;
  localparam int unsigned EW = SUMW + CNTW;
  localparam int unsigned D2U = rpsb_pkg::D2_USE_W;
  localparam int unsigned ITW = $clog2(SUMW);

  typedef enum logic [2:0] {
    ST_RUN, ST_FLUSH, ST_READ, ST_LOAD, ST_DIV, ST_PUT
  } state_e;

  function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SW'(1);
    end else if (CW'(v) > CW'(MAX_GRID)) begin
      r = SW'(MAX_GRID);
    end
    return r;
  endfunction

  function automatic logic signed [KW-1:0] wrap_comp(input logic [GW-1:0] g,
                                                    input logic [SW-1:0] n);
    logic signed [KW-1:0] r;
    r = $signed({1'b0, g});
    if (g > GW'(n >> 1)) begin
      r = $signed({1'b0, g}) - $signed(KW'(n));
    end
    return r;
  endfunction

  // configuration
  logic [SW-1:0] gx_q, gy_q, gz_q, pc_q;
  logic [rpsb_pkg::FIRST_W-1:0] first_q;
  logic [NW-1:0] nbin_q;
  logic [rpsb_pkg::NORM_W-1:0] norm_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q <= rpsb_pkg::RST_GRID_SIZE;
      gy_q <= rpsb_pkg::RST_GRID_SIZE;
      gz_q <= rpsb_pkg::RST_GRID_SIZE;
      pc_q <= rpsb_pkg::RST_GRID_SIZE;
      first_q <= rpsb_pkg::RST_FIRST_PLANE;
      nbin_q <= rpsb_pkg::RST_BIN_COUNT;
      norm_q <= rpsb_pkg::RST_POWER_NORM;
    end else if (cfg_valid_i) begin
      case (rpsb_pkg::cfg_reg_e'(cfg_index_i))
        rpsb_pkg::CFG_GRID_SIZE_X: gx_q <= cfg_data_i[SW-1:0];
        rpsb_pkg::CFG_GRID_SIZE_Y: gy_q <= cfg_data_i[SW-1:0];
        rpsb_pkg::CFG_GRID_SIZE_Z: gz_q <= cfg_data_i[SW-1:0];
        rpsb_pkg::CFG_SLAB_FIRST_PLANE: first_q <= cfg_data_i[rpsb_pkg::FIRST_W-1:0];
        rpsb_pkg::CFG_SLAB_PLANE_COUNT: pc_q <= cfg_data_i[SW-1:0];
        rpsb_pkg::CFG_BIN_COUNT: nbin_q <= cfg_data_i[NW-1:0];
        rpsb_pkg::CFG_POWER_NORM: norm_q <= cfg_data_i[rpsb_pkg::NORM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] n0c, n1c, n2c, npc, n0m2;
  logic [NW-1:0] nbc;
  logic [2*SW-1:0] n0sq_q;
  logic [2*NW-1:0] nb2_q;

  always_comb begin
    n0c = clamp_size(gx_q);
    n1c = clamp_size(gy_q);
    n2c = clamp_size(gz_q);
    npc = clamp_size(pc_q);
    n0m2 = n0c - SW'(2);
    nbc = nbin_q;
    if (nbin_q == '0) begin
      nbc = NW'(1);
    end else if (nbin_q > NW'(MAX_BINS)) begin
      nbc = NW'(MAX_BINS);
    end
  end

  always_ff @(posedge clk_i) begin
    n0sq_q <= n0c * n0c;
    nb2_q <= nbc * nbc;
  end

  // position tracking
  state_e state_q;
  logic in_acc;
  logic [PW-1:0] col_q, row_q, pln_q;
  logic [CW-1:0] col_inc, row_inc, pln_inc;
  logic col_wrap, row_wrap, pln_wrap;

  assign in_ready_o = (state_q == ST_RUN);
  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    col_inc = CW'(col_q) + CW'(1);
    row_inc = CW'(row_q) + CW'(1);
    pln_inc = CW'(pln_q) + CW'(1);
    col_wrap = col_inc >= CW'(n2c);
    row_wrap = col_wrap && (row_inc >= CW'(n1c));
    pln_wrap = row_wrap && (pln_inc >= CW'(npc));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pln_q <= '0;
    end else if (in_acc) begin
      col_q <= col_wrap ? '0 : col_inc[PW-1:0];
      if (col_wrap) begin
        row_q <= row_wrap ? '0 : row_inc[PW-1:0];
      end
      if (row_wrap) begin
        pln_q <= pln_wrap ? '0 : pln_inc[PW-1:0];
      end
    end
  end

  // front stages: power and squared distance, the power scaled by the norm, and the skip test
  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q;
  logic [rpsb_pkg::COEF_W-1:0] s0_mr_q, s0_mi_q;
  logic signed [KW-1:0] s0_k0_q, s0_k1_q, s0_k2_q;
  logic signed [2*KW-1:0] sq0, sq1, sq2;
  logic [SUMW-1:0] s1_sr_q, s1_si_q, s2_p_q, s3_ph_q, s3_pl_q, power;
  logic [2*GW-1:0] s1_kk0_q, s1_kk1_q, s1_kk2_q;
  logic [DW-1:0] s2_d2_q;
  logic s3_skip_q;
  logic [RW-1:0] s3_rhs_q;

  always_comb begin
    sq0 = s0_k0_q * s0_k0_q;
    sq1 = s0_k1_q * s0_k1_q;
    sq2 = s0_k2_q * s0_k2_q;
    power = s3_ph_q + {32'd0, s3_pl_q[SUMW-1:32]};
  end

  always_ff @(posedge clk_i) begin
    s0_mr_q <= coef_real_i[rpsb_pkg::COEF_W-1] ? 32'(-coef_real_i) : coef_real_i;
    s0_mi_q <= coef_imag_i[rpsb_pkg::COEF_W-1] ? 32'(-coef_imag_i) : coef_imag_i;
    s0_k0_q <= wrap_comp(GW'(first_q) + GW'(pln_q), n0c);
    s0_k1_q <= wrap_comp(GW'(row_q), n1c);
    s0_k2_q <= wrap_comp(GW'(col_q), n2c);
    s1_sr_q <= SUMW'(s0_mr_q) * SUMW'(s0_mr_q);
    s1_si_q <= SUMW'(s0_mi_q) * SUMW'(s0_mi_q);
    s1_kk0_q <= sq0[2*GW-1:0];
    s1_kk1_q <= sq1[2*GW-1:0];
    s1_kk2_q <= sq2[2*GW-1:0];
    s2_p_q <= s1_sr_q + s1_si_q;
    s2_d2_q <= DW'(s1_kk0_q) + DW'(s1_kk1_q) + DW'(s1_kk2_q);
    s3_ph_q <= SUMW'(s2_p_q[SUMW-1:32]) * SUMW'(norm_q);
    s3_pl_q <= SUMW'(s2_p_q[31:0]) * SUMW'(norm_q);
    s3_skip_q <= (s2_d2_q == '0) || ((DW+2)'({s2_d2_q, 2'b00}) >= (DW+2)'(n0sq_q));
    s3_rhs_q <= {(RW-2)'(nb2_q) * (RW-2)'(s2_d2_q[D2U-1:0]), 2'b00};
  end

  // bin search: one bit of the bin per two stages
  logic [SD:0] sv_q;
  logic [BW-1:0] sb_q [SD+1];
  logic [BW-1:0] sc_q [SD+1];
  logic [LW-1:0] sl_q [SD+1];
  logic [SUMW-1:0] sp_q [SD+1];
  logic [RW-1:0] sr_q [SD+1];

  always_ff @(posedge clk_i) begin
    sb_q[0] <= '0;
    sc_q[0] <= '0;
    sl_q[0] <= '0;
    sp_q[0] <= power;
    sr_q[0] <= s3_rhs_q;
  end

  for (genvar i = 1; i <= SD; i++) begin : g_srch
    localparam int unsigned J = (i - 1) / 2;
    if (i % 2 == 1) begin : g_lhs
      logic [BW-1:0] cand;
      assign cand = sb_q[i-1] | (BW'(1) << (BW - 1 - J));
      always_ff @(posedge clk_i) begin
        sc_q[i] <= cand;
        sl_q[i] <= LW'({nbc, 1'b0}) + LW'(cand) * LW'(n0m2);
        sb_q[i] <= sb_q[i-1];
        sp_q[i] <= sp_q[i-1];
        sr_q[i] <= sr_q[i-1];
      end
    end else begin : g_cmp
      logic fits;
      assign fits = (NW'(sc_q[i-1]) < nbc) && ((sl_q[i-1] * sl_q[i-1]) <= sr_q[i-1]);
      always_ff @(posedge clk_i) begin
        sc_q[i] <= sc_q[i-1];
        sl_q[i] <= sl_q[i-1];
        sb_q[i] <= fits ? sc_q[i-1] : sb_q[i-1];
        sp_q[i] <= sp_q[i-1];
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  // bin store read-modify-write
  logic m_v_q;
  logic [BW-1:0] m_bin_q, dbin_q;
  logic [SUMW-1:0] m_pow_q;
  logic [MAX_BINS-1:0] vld_q;
  logic rd_vld_q, fwd_v_q, re;
  logic [BW-1:0] raddr, rd_addr_q, fwd_addr_q;
  logic [EW-1:0] rdata, ent, wdata, fwd_data_q;
  logic [SUMW:0] nsum;
  logic [CNTW-1:0] ecnt;
  logic vld_clr;

  always_comb begin
    re = sv_q[SD] || (state_q == ST_READ);
    raddr = (state_q == ST_READ) ? dbin_q : sb_q[SD];
    if (fwd_v_q && (fwd_addr_q == rd_addr_q)) begin
      ent = fwd_data_q;
    end else if (rd_vld_q) begin
      ent = rdata;
    end else begin
      ent = '0;
    end
    ecnt = ent[EW-1:SUMW];
    nsum = {1'b0, ent[SUMW-1:0]} + {1'b0, m_pow_q};
    wdata[SUMW-1:0] = nsum[SUMW] ? {SUMW{1'b1}} : nsum[SUMW-1:0];
    wdata[EW-1:SUMW] = (&ecnt) ? ecnt : ecnt + CNTW'(1);
  end

  rpsb_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_BINS),
    .AW(BW)
  ) u_bin_ram (
    .clk_i  (clk_i),
    .we_i   (m_v_q),
    .waddr_i(m_bin_q),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      sv_q <= '0;
      m_v_q <= 1'b0;
      fwd_v_q <= 1'b0;
      vld_q <= '0;
    end else begin
      s0_v_q <= in_acc;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      sv_q <= {sv_q[SD-1:0], s3_v_q && !s3_skip_q};
      m_v_q <= sv_q[SD];
      fwd_v_q <= m_v_q;
      if (vld_clr) begin
        vld_q <= '0;
      end else if (m_v_q) begin
        vld_q[m_bin_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_bin_q <= sb_q[SD];
    m_pow_q <= sp_q[SD];
    fwd_addr_q <= m_bin_q;
    fwd_data_q <= wdata;
    if (re) begin
      rd_addr_q <= raddr;
      rd_vld_q <= vld_q[raddr];
    end
  end

  // drain: read each bin, divide, hand out
  logic pipe_busy, put_go, drain_end;
  logic [SUMW-1:0] dq_q;
  logic [CNTW-1:0] dd_q, rem_q;
  logic [CNTW:0] shft;
  logic [ITW-1:0] it_q;
  logic out_valid_q;

  always_comb begin
    pipe_busy = s0_v_q || s1_v_q || s2_v_q || s3_v_q || (|sv_q) || m_v_q;
    shft = {rem_q, dq_q[SUMW-1]};
    put_go = (state_q == ST_PUT) && (!out_valid_q || out_ready_i);
    drain_end = NW'(dbin_q) == (nbc - NW'(1));
    vld_clr = put_go && drain_end;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      dbin_q <= '0;
      out_valid_q <= 1'b0;
      it_q <= '0;
      dq_q <= '0;
      dd_q <= '0;
      rem_q <= '0;
      bin_index_o <= '0;
      mean_power_o <= '0;
      point_count_o <= '0;
      last_bin_o <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !put_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_RUN: begin
          if (in_acc && pln_wrap) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!pipe_busy) begin
            dbin_q <= '0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          dq_q <= ent[SUMW-1:0];
          dd_q <= ecnt;
          rem_q <= '0;
          it_q <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (shft >= {1'b0, dd_q}) begin
            rem_q <= CNTW'(shft - {1'b0, dd_q});
            dq_q <= {dq_q[SUMW-2:0], 1'b1};
          end else begin
            rem_q <= shft[CNTW-1:0];
            dq_q <= {dq_q[SUMW-2:0], 1'b0};
          end
          it_q <= it_q + ITW'(1);
          if (&it_q) begin
            state_q <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (put_go) begin
            out_valid_q <= 1'b1;
            bin_index_o <= rpsb_pkg::BIN_IDX_W'(dbin_q);
            mean_power_o <= (dd_q == '0) ? '0 : dq_q;
            point_count_o <= dd_q;
            last_bin_o <= drain_end;
            if (drain_end) begin
              state_q <= ST_RUN;
            end else begin
              dbin_q <= dbin_q + BW'(1);
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  // checks
  a_store_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_v_q |-> (state_q == ST_RUN || state_q == ST_FLUSH))
    else $error("bin store written during drain");

  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sv_q[SD] && state_q == ST_READ))
    else $error("pipeline and drain read the bin store together");

  a_clear_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_clr |=> (vld_q == '0) && (state_q == ST_RUN))
    else $error("bin store not cleared after last bin");

  a_flush_before_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && !pipe_busy) |=> !pipe_busy)
    else $error("item entered pipeline during flush");

endmodule
`default_nettype wire
